// ===== hdl/sls_pkg.sv =====
// shared types, codes and widths for the seekable line stepper
`timescale 1ns / 1ps

package sls_pkg;

  // default coordinate width of the endpoint and target ports
  localparam int COORD_BITS_DEF = 13;

  // fixed field widths
  localparam int STEP_W      = 13;
  localparam int COUNT_W     = 14;
  localparam int OUT_COORD_W = 14;
  localparam int MAJ_LEN_W   = 13;
  localparam int DELTA_W     = 15;
  localparam int QUO_W       = 15;
  localparam int CNT_W       = QUO_W + 1;
  localparam int INC_W       = 2;
  localparam int OUT_TDATA_W = 88;

  // request command codes
  localparam logic [1:0] CMD_BEGIN = 2'd0;
  localparam logic [1:0] CMD_SEEK  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  // register indexes on the config port
  localparam logic [2:0] REG_START_X = 3'd0;
  localparam logic [2:0] REG_START_Y = 3'd1;
  localparam logic [2:0] REG_END_X   = 3'd2;
  localparam logic [2:0] REG_END_Y   = 3'd3;
  localparam logic [2:0] REG_AA_ON   = 3'd4;

  // controller to datapath commands
  typedef struct packed {
    logic latch;
    logic do_begin;
    logic do_query;
    logic do_seek;
    logic do_acc;
    logic div_start;
    logic do_corr;
    logic load_out;
  } sls_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic delta_zero;
    logic den_zero;
    logic div_done;
  } sls_stat_t;

endpackage

// ===== hdl/sls_div.sv =====
// iterative restoring divider, signed dividend, truncating quotient
`timescale 1ns / 1ps

module sls_div import sls_pkg::*; #(
  parameter int DVD_W = 30,
  parameter int DVS_W = 14,
  parameter int Q_W   = QUO_W
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [DVD_W-1:0] dividend,
  input  logic        [DVS_W-1:0] divisor,
  output logic                    done,
  output logic signed [Q_W:0]     quotient
);

  localparam int SH_W  = DVS_W + Q_W - 1;
  localparam int CMP_W = (DVD_W > SH_W) ? DVD_W : SH_W;
  localparam int IT_W  = $clog2(Q_W + 1);

  logic [CMP_W-1:0] rem;
  logic [SH_W-1:0]  dsh;
  logic [Q_W-1:0]   quo;
  logic             neg;
  logic [IT_W-1:0]  iter;
  logic             busy;
  logic [DVD_W-1:0] mag;
  logic             ge;

  // magnitude of the dividend and one trial subtract per cycle
  always_comb begin
    mag = dividend[DVD_W-1] ? $unsigned(-dividend) : $unsigned(dividend);
    ge  = rem >= CMP_W'(dsh);
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      iter <= '0;
    end else if (start) begin
      busy <= 1'b1;
      iter <= IT_W'(Q_W);
    end else if (busy) begin
      iter <= iter - IT_W'(1);
      if (iter == IT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // remainder, shifted divisor and quotient bits
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= CMP_W'(mag);
      dsh <= SH_W'(divisor) << (Q_W - 1);
      quo <= '0;
      neg <= dividend[DVD_W-1];
    end else if (busy) begin
      if (ge) begin
        rem <= rem - CMP_W'(dsh);
      end
      quo <= {quo[Q_W-2:0], ge};
      dsh <= dsh >> 1;
    end
  end

  assign done     = busy && (iter == IT_W'(1));
  assign quotient = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

endmodule

// ===== hdl/sls_dp.sv =====
// line stepper datapath: setup, seek, query and result register
`timescale 1ns / 1ps

module sls_dp import sls_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sls_cmd_t                      cmd,
  output sls_stat_t                     stat,
  input  logic        [COORD_BITS-1:0]  start_x,
  input  logic        [COORD_BITS-1:0]  start_y,
  input  logic        [COORD_BITS-1:0]  end_x,
  input  logic        [COORD_BITS-1:0]  end_y,
  input  logic                          antialias_on,
  input  logic        [STEP_W-1:0]      step_in,
  input  logic        [COORD_BITS-1:0]  tx_in,
  input  logic        [COORD_BITS-1:0]  ty_in,
  input  logic                          aa_sel_in,
  output logic        [OUT_TDATA_W-1:0] m_tdata
);

  localparam int C     = COORD_BITS;
  localparam int ACC_W = C + 17;
  localparam int QD_W  = C + 3;
  localparam int SEL_W = C + STEP_W;

  localparam logic signed [INC_W-1:0] INC_POS  = 2'sb01;
  localparam logic signed [INC_W-1:0] INC_NEG  = 2'sb11;
  localparam logic signed [INC_W-1:0] INC_ZERO = 2'sb00;

  // line state
  logic signed [C-1:0]           org_x, org_y;
  logic                          line_aa;
  logic signed [INC_W-1:0]       maj_inc_x, maj_inc_y, min_inc_x, min_inc_y;
  logic signed [INC_W-1:0]       aa_off_x, aa_off_y;
  logic        [C-1:0]           span_major;
  logic        [COUNT_W-1:0]     step_count;
  logic        [C:0]             err_num, err_den;
  logic signed [ACC_W-1:0]       err_accum;
  logic signed [1:0]             err_target;
  logic signed [OUT_COORD_W-1:0] cur_x, cur_y;

  // per-request registers
  logic        [STEP_W-1:0]      step_lat;
  logic signed [C-1:0]           tx_lat, ty_lat;
  logic                          aa_sel_lat;
  logic signed [DELTA_W-1:0]     delta;
  logic        [COUNT_W-1:0]     steps;

  // begin setup terms
  logic signed [C-1:0]           x1, y1, x2, y2;
  logic signed [C:0]             dx, dy;
  logic        [C-1:0]           adx, ady, b_amaj, b_amin;
  logic                          xmajor, b_maj_neg, b_same;
  logic signed [INC_W-1:0]       b_maj_x, b_maj_y, b_min_x, b_min_y, b_off_x, b_off_y;
  logic        [ACC_W-1:0]       b_accum;
  logic signed [1:0]             b_target;

  // seek terms
  logic        [STEP_W-1:0]      clamped;
  logic        [COUNT_W-1:0]     step_next;
  logic signed [DELTA_W-1:0]     delta_c;
  logic signed [ACC_W-1:0]       acc_prod, corr_prod, div_n;
  logic                          div_done;
  logic signed [CNT_W-1:0]       cnt;

  // query terms
  logic signed [INC_W-1:0]       sel_off_x, sel_off_y;
  logic signed [QD_W-1:0]        ex, ey, dq, len_s;
  logic        [C:0]             len;
  logic        [COUNT_W-1:0]     q_steps;

  // result terms
  logic signed [ACC_W:0]         need_sum;
  logic                          need;
  logic signed [OUT_COORD_W-1:0] aa_x, aa_y;

  // move a coordinate by a signed amount along a unit direction
  function automatic logic signed [OUT_COORD_W-1:0] mov(
    input logic signed [OUT_COORD_W-1:0] pos,
    input logic signed [INC_W-1:0]       inc,
    input logic signed [OUT_COORD_W-1:0] amt
  );
    logic signed [OUT_COORD_W-1:0] r;
    if (inc == INC_POS) begin
      r = pos + amt;
    end else if (inc == INC_NEG) begin
      r = pos - amt;
    end else begin
      r = pos;
    end
    return r;
  endfunction

  // project a distance onto a unit direction
  function automatic logic signed [QD_W-1:0] proj(
    input logic signed [INC_W-1:0] inc,
    input logic signed [QD_W-1:0]  v
  );
    logic signed [QD_W-1:0] r;
    if (inc == INC_POS) begin
      r = v;
    end else if (inc == INC_NEG) begin
      r = -v;
    end else begin
      r = '0;
    end
    return r;
  endfunction

  // line setup from the endpoints
  always_comb begin
    x1 = $signed(start_x);
    y1 = $signed(start_y);
    x2 = $signed(end_x);
    y2 = $signed(end_y);
    dx = (C+1)'(x2) - (C+1)'(x1);
    dy = (C+1)'(y2) - (C+1)'(y1);
    adx = dx[C] ? C'(-dx) : C'(dx);
    ady = dy[C] ? C'(-dy) : C'(dy);
    xmajor = adx >= ady;
    if (xmajor) begin
      b_maj_x = dx[C] ? INC_NEG : INC_POS;
      b_maj_y = INC_ZERO;
      b_min_x = INC_ZERO;
      b_min_y = dy[C] ? INC_NEG : INC_POS;
      b_amaj = adx;
      b_amin = ady;
      b_maj_neg = dx[C];
    end else begin
      b_maj_x = INC_ZERO;
      b_maj_y = dy[C] ? INC_NEG : INC_POS;
      b_min_x = dx[C] ? INC_NEG : INC_POS;
      b_min_y = INC_ZERO;
      b_amaj = ady;
      b_amin = adx;
      b_maj_neg = dy[C];
    end
    b_same = (x1 > x2) == (y1 > y2);
    b_accum = ACC_W'(b_amaj) + ACC_W'(1) + ACC_W'({b_amin, 1'b0}) - ACC_W'(antialias_on);
    b_target = antialias_on ? 2'sb11 : (b_maj_neg ? 2'sb01 : 2'sb00);
    b_off_x = INC_ZERO;
    b_off_y = INC_ZERO;
    if (antialias_on) begin
      if (xmajor) begin
        b_off_x = b_same ? INC_ZERO : -b_maj_x;
        b_off_y = b_same ? -b_min_y : INC_ZERO;
      end else begin
        b_off_x = b_same ? INC_ZERO : -b_min_x;
        b_off_y = b_same ? -b_maj_y : INC_ZERO;
      end
    end
  end

  // seek: clamp, step difference and the error products
  always_comb begin
    if (SEL_W'(step_lat) > SEL_W'(span_major)) begin
      clamped = STEP_W'(span_major);
    end else begin
      clamped = step_lat;
    end
    step_next = COUNT_W'(clamped) + COUNT_W'(1);
    delta_c   = $signed(DELTA_W'(step_next)) - $signed(DELTA_W'(step_count));
    acc_prod  = $signed({1'b0, err_num}) * delta;
    div_n     = ACC_W'(err_target) - err_accum + $signed(ACC_W'(err_den));
    corr_prod = $signed({1'b0, err_den}) * cnt;
  end

  sls_div #(
    .DVD_W (ACC_W),
    .DVS_W (C + 1),
    .Q_W   (QUO_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_n),
    .divisor  (err_den),
    .done     (div_done),
    .quotient (cnt)
  );

  // query: steps from the line start along the major axis
  always_comb begin
    sel_off_x = aa_sel_lat ? aa_off_x : INC_ZERO;
    sel_off_y = aa_sel_lat ? aa_off_y : INC_ZERO;
    ex = QD_W'(tx_lat) - QD_W'(org_x) - QD_W'(sel_off_x);
    ey = QD_W'(ty_lat) - QD_W'(org_y) - QD_W'(sel_off_y);
    dq = proj(maj_inc_x, ex) + proj(maj_inc_y, ey);
    len = (C+1)'(span_major) + (C+1)'(1);
    len_s = $signed(QD_W'(len));
    if (dq < 0 || dq >= len_s) begin
      q_steps = COUNT_W'(len);
    end else begin
      q_steps = COUNT_W'(dq);
    end
  end

  // antialias flag and pixel
  always_comb begin
    need_sum = (ACC_W+1)'(err_accum) - $signed((ACC_W+1)'(err_den))
             + $signed((ACC_W+1)'(err_num));
    need = line_aa && (step_count > COUNT_W'(1)) && (need_sum > (ACC_W+1)'(err_target));
    aa_x = cur_x + OUT_COORD_W'(aa_off_x);
    aa_y = cur_y + OUT_COORD_W'(aa_off_y);
  end

  assign stat.delta_zero = (step_next == step_count);
  assign stat.den_zero   = (err_den == '0);
  assign stat.div_done   = div_done;

  // line state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      org_x      <= '0;
      org_y      <= '0;
      line_aa    <= 1'b0;
      maj_inc_x  <= INC_ZERO;
      maj_inc_y  <= INC_ZERO;
      min_inc_x  <= INC_ZERO;
      min_inc_y  <= INC_ZERO;
      aa_off_x   <= INC_ZERO;
      aa_off_y   <= INC_ZERO;
      span_major <= '0;
      step_count <= '0;
      err_num    <= '0;
      err_den    <= '0;
      err_accum  <= '0;
      err_target <= '0;
      cur_x      <= '0;
      cur_y      <= '0;
    end else if (cmd.do_begin) begin
      org_x      <= x1;
      org_y      <= y1;
      line_aa    <= antialias_on;
      maj_inc_x  <= b_maj_x;
      maj_inc_y  <= b_maj_y;
      min_inc_x  <= b_min_x;
      min_inc_y  <= b_min_y;
      aa_off_x   <= b_off_x;
      aa_off_y   <= b_off_y;
      span_major <= b_amaj;
      step_count <= '0;
      err_num    <= {b_amin, 1'b0};
      err_den    <= {b_amaj, 1'b0};
      err_accum  <= $signed(b_accum);
      err_target <= b_target;
      cur_x      <= OUT_COORD_W'(x1) - OUT_COORD_W'(b_maj_x);
      cur_y      <= OUT_COORD_W'(y1) - OUT_COORD_W'(b_maj_y);
    end else if (cmd.do_seek) begin
      step_count <= step_next;
      cur_x      <= mov(cur_x, maj_inc_x, OUT_COORD_W'(delta_c));
      cur_y      <= mov(cur_y, maj_inc_y, OUT_COORD_W'(delta_c));
    end else if (cmd.do_acc) begin
      err_accum  <= err_accum - acc_prod;
    end else if (cmd.do_corr) begin
      err_accum  <= err_accum + corr_prod;
      cur_x      <= mov(cur_x, min_inc_x, OUT_COORD_W'(cnt));
      cur_y      <= mov(cur_y, min_inc_y, OUT_COORD_W'(cnt));
    end
  end

  // request fields, step difference and query answer
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      step_lat   <= step_in;
      tx_lat     <= $signed(tx_in);
      ty_lat     <= $signed(ty_in);
      aa_sel_lat <= aa_sel_in;
      steps      <= '0;
    end else if (cmd.do_query) begin
      steps      <= q_steps;
    end
    if (cmd.do_seek) begin
      delta <= delta_c;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= OUT_TDATA_W'({MAJ_LEN_W'(span_major), need, aa_y, aa_x, cur_y, cur_x, steps});
    end
  end

endmodule

// ===== hdl/sls_ctrl.sv =====
// line stepper controller: request sequencing and result handshake
`timescale 1ns / 1ps

module sls_ctrl import sls_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic [1:0] s_tuser,
  output logic       s_tready,
  output logic       m_tvalid,
  input  logic       m_tready,
  output sls_cmd_t   cmd,
  input  sls_stat_t  stat
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_BEGIN  = 4'd1;
  localparam logic [3:0] ST_QUERY  = 4'd2;
  localparam logic [3:0] ST_SEEK   = 4'd3;
  localparam logic [3:0] ST_ACC    = 4'd4;
  localparam logic [3:0] ST_DSTART = 4'd5;
  localparam logic [3:0] ST_DWAIT  = 4'd6;
  localparam logic [3:0] ST_CORR   = 4'd7;
  localparam logic [3:0] ST_OUT    = 4'd8;

  logic [3:0] state, state_next;

  assign s_tready = (state == ST_IDLE);

  // next state and datapath commands
  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.latch = 1'b1;
          unique case (s_tuser)
            CMD_BEGIN: state_next = ST_BEGIN;
            CMD_SEEK:  state_next = ST_SEEK;
            CMD_QUERY: state_next = ST_QUERY;
            default:   state_next = ST_OUT;
          endcase
        end
      end
      ST_BEGIN: begin
        cmd.do_begin = 1'b1;
        state_next = ST_OUT;
      end
      ST_QUERY: begin
        cmd.do_query = 1'b1;
        state_next = ST_OUT;
      end
      ST_SEEK: begin
        if (stat.delta_zero) begin
          state_next = ST_OUT;
        end else begin
          cmd.do_seek = 1'b1;
          state_next = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.do_acc = 1'b1;
        state_next = stat.den_zero ? ST_OUT : ST_DSTART;
      end
      ST_DSTART: begin
        cmd.div_start = 1'b1;
        state_next = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (stat.div_done) begin
          state_next = ST_CORR;
        end
      end
      ST_CORR: begin
        cmd.do_corr = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          cmd.load_out = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state register and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/seekable_line_stepper_aa.sv =====
// top level: config registers, stream ports, controller and datapath
// begin, query: one work state, then the output state; unused requests skip to the output state
// seek: step, accumulate, divider start, divider wait and correction states, then the output state;
//   a single-point line skips the divider and correction, an unchanged step skips to the output state
// a new request is taken while the previous result still waits on the output register
// rst (synchronous, active high) clears the config registers and all line state to zero
`timescale 1ns / 1ps

module seekable_line_stepper_aa import sls_pkg::*; #(
  parameter  int COORD_BITS = COORD_BITS_DEF,
  localparam int IN_TDATA_W = ((2 * COORD_BITS + STEP_W + 1 + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [4:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // step_index, target_x, target_y, use_aa_offset
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // cmd
  input  logic [1:0]             s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // steps_needed, pos_x, pos_y, aa_x, aa_y, needs_aa, major_length
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  logic [COORD_BITS-1:0] start_x, start_y, end_x, end_y;
  logic                  antialias_on;
  sls_cmd_t              cmd;
  sls_stat_t             stat;

  assign pready = 1'b1;

  // config register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      start_x      <= '0;
      start_y      <= '0;
      end_x        <= '0;
      end_y        <= '0;
      antialias_on <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[4:2])
        REG_START_X: start_x      <= pwdata[COORD_BITS-1:0];
        REG_START_Y: start_y      <= pwdata[COORD_BITS-1:0];
        REG_END_X:   end_x        <= pwdata[COORD_BITS-1:0];
        REG_END_Y:   end_y        <= pwdata[COORD_BITS-1:0];
        REG_AA_ON:   antialias_on <= pwdata[0];
        default: ;
      endcase
    end
  end

  // config register reads
  always_comb begin
    unique case (paddr[4:2])
      REG_START_X: prdata = 32'(start_x);
      REG_START_Y: prdata = 32'(start_y);
      REG_END_X:   prdata = 32'(end_x);
      REG_END_Y:   prdata = 32'(end_y);
      REG_AA_ON:   prdata = 32'(antialias_on);
      default:     prdata = '0;
    endcase
  end

  sls_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  sls_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .start_x      (start_x),
    .start_y      (start_y),
    .end_x        (end_x),
    .end_y        (end_y),
    .antialias_on (antialias_on),
    .step_in      (s_tdata[STEP_W-1:0]),
    .tx_in        (s_tdata[STEP_W +: COORD_BITS]),
    .ty_in        (s_tdata[STEP_W + COORD_BITS +: COORD_BITS]),
    .aa_sel_in    (s_tdata[STEP_W + 2 * COORD_BITS]),
    .m_tdata      (m_tdata)
  );

endmodule

// ===== hdl/sls_checker.sv =====
// port-level checks for the line stepper and their bind to the top level
`timescale 1ns / 1ps

module sls_checker import sls_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its data
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result data changed while stalled");

  // one request at a time: ready drops after a request is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while another is in work");

  // a new result appears only as the block returns to idle
  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> s_tready)
    else $error("result raised while still busy");

  // reset leaves no result and an idle block
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("reset did not clear the handshake state");

endmodule

bind seekable_line_stepper_aa sls_checker u_sls_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== tb/testbench.sv =====
// testbench for the line stepper: directed request table, then random lines checked by a predictor
`timescale 1ns / 1ps

module testbench import sls_pkg::*; ();

  localparam int IN_W        = ((2 * COORD_BITS_DEF + STEP_W + 1 + 7) / 8) * 8;
  localparam int ITEMS_TOTAL = 1650;
  // cmd code with no function in the block
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [12:0] step;
    logic [12:0] tx;
    logic [12:0] ty;
    logic        use_off;
  } req_t;

  typedef struct packed {
    logic [13:0] steps;
    logic [13:0] pos_x;
    logic [13:0] pos_y;
    logic [13:0] aa_x;
    logic [13:0] aa_y;
    logic        needs_aa;
    logic [12:0] major;
  } result_t;

  typedef struct packed {
    logic        is_cfg;
    logic [2:0]  idx;
    logic [12:0] val;
    req_t        req;
    logic        typed;
    result_t     res;
  } dir_row_t;

  logic                   clk;
  logic                   rst     = 1'b1;
  logic                   psel    = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite  = 1'b0;
  logic [4:0]             paddr   = '0;
  logic [31:0]            pwdata  = '0;
  logic [31:0]            prdata;
  logic                   pready;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // step_index, target_x, target_y, use_aa_offset
  logic [IN_W-1:0]        s_tdata  = '0;
  // cmd
  logic [1:0]             s_tuser  = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // steps_needed, pos_x, pos_y, aa_x, aa_y, needs_aa, major_length
  logic [OUT_TDATA_W-1:0] m_tdata;

  seekable_line_stepper_aa dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // predictor copy of the config registers
  logic [12:0] cfg_sx = '0, cfg_sy = '0, cfg_ex = '0, cfg_ey = '0;
  logic        cfg_aa = 1'b0;

  // predictor copy of the line state
  longint e_num = 0, e_den = 0, e_acc = 0, e_tgt = 0;
  longint mj_x = 0, mj_y = 0, mn_x = 0, mn_y = 0;
  longint px = 0, py = 0, n_step = 0, span = 0;
  longint off_x = 0, off_y = 0, org_x = 0, org_y = 0;
  logic   line_aa = 1'b0;

  result_t  pending_results[$];
  dir_row_t directed_rows[$];
  int       mismatch_count = 0;
  int       items_sent = 0;
  int       burst_left = 0;
  logic     steady_tx = 1'b0;
  logic     hold_req = 1'b0;
  int       hold_cnt = 0;
  int       rx_left = 0;
  int       rx_mode = 0;
  int       rx_cyc = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #(10_000_000);
    $display("Regression FAIL");
    $finish;
  end

  // expected result of one request, advancing the line state
  function automatic result_t stepper_predict(req_t r);
    longint x1, y1, x2, y2, dx, dy, adx, ady, dmaj, amaj, amin;
    longint s, dlt, cnt, dd, len;
    logic xmaj, same, need;
    result_t res;
    res.steps = '0;
    case (r.cmd)
      CMD_BEGIN: begin
        x1 = longint'($signed(cfg_sx));
        y1 = longint'($signed(cfg_sy));
        x2 = longint'($signed(cfg_ex));
        y2 = longint'($signed(cfg_ey));
        dx = x2 - x1;
        dy = y2 - y1;
        adx = dx < 0 ? -dx : dx;
        ady = dy < 0 ? -dy : dy;
        xmaj = adx >= ady;
        org_x = x1;
        org_y = y1;
        line_aa = cfg_aa;
        if (xmaj) begin
          mj_x = dx >= 0 ? 1 : -1; mj_y = 0;
          mn_x = 0; mn_y = dy >= 0 ? 1 : -1;
          dmaj = dx; amaj = adx; amin = ady;
        end else begin
          mj_x = 0; mj_y = dy >= 0 ? 1 : -1;
          mn_x = dx >= 0 ? 1 : -1; mn_y = 0;
          dmaj = dy; amaj = ady; amin = adx;
        end
        span = amaj;
        n_step = 0;
        e_num = amin * 2;
        e_den = amaj * 2;
        e_acc = amaj + 1 + e_num;
        e_tgt = (!cfg_aa && dmaj < 0) ? 1 : 0;
        px = x1 - mj_x;
        py = y1 - mj_y;
        off_x = 0;
        off_y = 0;
        // antialias pixel sits on the side away from the step direction
        if (cfg_aa) begin
          same = (x1 > x2) == (y1 > y2);
          e_acc = e_acc - 1;
          e_tgt = e_tgt - 1;
          if (xmaj) begin
            off_x = same ? 0 : -mj_x;
            off_y = same ? -mn_y : 0;
          end else begin
            off_x = same ? 0 : -mn_x;
            off_y = same ? -mj_y : 0;
          end
        end
      end
      CMD_SEEK: begin
        s = longint'(r.step);
        if (s > span) s = span;
        dlt = s + 1 - n_step;
        if (dlt != 0) begin
          n_step = s + 1;
          px = px + mj_x * dlt;
          py = py + mj_y * dlt;
          e_acc = e_acc - e_num * dlt;
          // minor axis catch-up, truncating division
          if (e_den != 0) begin
            cnt = (e_tgt - e_acc + e_den) / e_den;
            e_acc = e_acc + e_den * cnt;
            px = px + mn_x * cnt;
            py = py + mn_y * cnt;
          end
        end
      end
      CMD_QUERY: begin
        dd = (longint'($signed(r.tx)) - org_x - (r.use_off ? off_x : 0)) * mj_x +
             (longint'($signed(r.ty)) - org_y - (r.use_off ? off_y : 0)) * mj_y;
        len = span + 1;
        res.steps = (dd < 0 || dd >= len) ? 14'(len) : 14'(dd);
      end
      default: ;
    endcase
    need = line_aa && n_step > 1 && (e_acc - e_den + e_num > e_tgt);
    res.pos_x    = 14'(px);
    res.pos_y    = 14'(py);
    res.aa_x     = 14'(px + off_x);
    res.aa_y     = 14'(py + off_y);
    res.needs_aa = need;
    res.major    = 13'(span);
    return res;
  endfunction

  function automatic result_t mk_res(int st, int x, int y, int ax, int ay, int nd, int mj);
    result_t res;
    res.steps    = 14'(st);
    res.pos_x    = 14'(x);
    res.pos_y    = 14'(y);
    res.aa_x     = 14'(ax);
    res.aa_y     = 14'(ay);
    res.needs_aa = 1'(nd);
    res.major    = 13'(mj);
    return res;
  endfunction

  // table rows
  function automatic void dir_cfg(logic [2:0] idx, int val);
    dir_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.val = 13'(val);
    directed_rows.push_back(row);
  endfunction

  function automatic void dir_req(logic [1:0] c, int st, int tx, int ty, logic u,
                                  logic typed = 1'b0, result_t e = '0);
    dir_row_t row;
    row = '0;
    row.req.cmd = c;
    row.req.step = 13'(st);
    row.req.tx = 13'(tx);
    row.req.ty = 13'(ty);
    row.req.use_off = u;
    row.typed = typed;
    row.res = e;
    directed_rows.push_back(row);
  endfunction

  // register write: setup then access phase
  task automatic apb_write(logic [2:0] idx, int val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_START_X: cfg_sx = 13'(val);
      REG_START_Y: cfg_sy = 13'(val);
      REG_END_X:   cfg_ex = 13'(val);
      REG_END_Y:   cfg_ey = 13'(val);
      REG_AA_ON:   cfg_aa = 1'(val);
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // drop the request stream and wait for every result
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // offer one request in bursts with random gaps, predict on acceptance
  task automatic send_req(req_t r, logic typed, result_t tv);
    int gap;
    result_t pred;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = steady_tx ? 0 :
            ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata <= {r.use_off, r.ty, r.tx, r.step};
    s_tuser <= r.cmd;
    do @(posedge clk); while (!s_tready);
    burst_left--;
    items_sent++;
    pred = stepper_predict(r);
    pending_results.push_back(typed ? tv : pred);
  endtask

  task automatic check_field(string nm, logic [13:0] e, logic [13:0] a);
    if (e !== a) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, nm, e, a);
    end
  endtask

  // receiver: long hold once on request, otherwise changing stall patterns
  always @(negedge clk) begin
    if (hold_req) begin
      hold_cnt = 400;
      hold_req = 1'b0;
    end
    rx_cyc++;
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(20, 200);
      end
      rx_left--;
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        2: m_tready <= (rx_cyc % 7) < 3;
        default: m_tready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin : result_check
    result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.steps    = m_tdata[13:0];
      got.pos_x    = m_tdata[27:14];
      got.pos_y    = m_tdata[41:28];
      got.aa_x     = m_tdata[55:42];
      got.aa_y     = m_tdata[69:56];
      got.needs_aa = m_tdata[70];
      got.major    = m_tdata[83:71];
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with no request outstanding, expected none, got %h",
                 $time, m_tdata);
      end else begin
        want = pending_results.pop_front();
        check_field("steps_needed", want.steps, got.steps);
        check_field("pos_x", want.pos_x, got.pos_x);
        check_field("pos_y", want.pos_y, got.pos_y);
        check_field("aa_x", want.aa_x, got.aa_x);
        check_field("aa_y", want.aa_y, got.aa_y);
        check_field("needs_aa", 14'(want.needs_aa), 14'(got.needs_aa));
        check_field("major_length", 14'(want.major), 14'(got.major));
      end
    end
  end

  // stimulus
  initial begin
    req_t r;
    int   pick, n, k, sel, t, m, tx, ty;
    int   lx0, ly0, lx1, ly1, cx, cy;
    logic noise, first_phase;

    // before any line: stepper parked at the origin
    dir_req(CMD_QUERY, 0, 0, 0, 1'b0, 1'b1, mk_res(0, 0, 0, 0, 0, 0, 0));
    dir_req(CMD_SEEK, 8191, 0, 0, 1'b0, 1'b1, mk_res(0, 0, 0, 0, 0, 0, 0));
    dir_req(CMD_UNUSED, 8191, -1, -1, 1'b1, 1'b1, mk_res(0, 0, 0, 0, 0, 0, 0));
    // short horizontal line, antialias off
    dir_cfg(REG_START_X, 0);
    dir_cfg(REG_START_Y, 0);
    dir_cfg(REG_END_X, 10);
    dir_cfg(REG_END_Y, 0);
    dir_cfg(REG_AA_ON, 0);
    dir_req(CMD_BEGIN, 0, 0, 0, 1'b0, 1'b1, mk_res(0, -1, 0, -1, 0, 0, 10));
    dir_req(CMD_SEEK, 5, 0, 0, 1'b0, 1'b1, mk_res(0, 5, 0, 5, 0, 0, 10));
    dir_req(CMD_SEEK, 5, 0, 0, 1'b0, 1'b1, mk_res(0, 5, 0, 5, 0, 0, 10));
    dir_req(CMD_SEEK, 8191, 0, 0, 1'b0, 1'b1, mk_res(0, 10, 0, 10, 0, 0, 10));
    dir_req(CMD_QUERY, 0, 7, 0, 1'b0, 1'b1, mk_res(7, 10, 0, 10, 0, 0, 10));
    dir_req(CMD_QUERY, 0, 11, 0, 1'b0, 1'b1, mk_res(11, 10, 0, 10, 0, 0, 10));
    dir_req(CMD_QUERY, 0, -1, 0, 1'b0, 1'b1, mk_res(11, 10, 0, 10, 0, 0, 10));
    // full-range diagonal with antialias
    dir_cfg(REG_START_X, -4096);
    dir_cfg(REG_START_Y, -4096);
    dir_cfg(REG_END_X, 4095);
    dir_cfg(REG_END_Y, 4095);
    dir_cfg(REG_AA_ON, 1);
    dir_req(CMD_BEGIN, 0, 0, 0, 1'b0);
    dir_req(CMD_SEEK, 8191, 0, 0, 1'b0);
    dir_req(CMD_SEEK, 3, 0, 0, 1'b0);
    dir_req(CMD_QUERY, 0, -4091, -4091, 1'b1);
    dir_req(CMD_UNUSED, 0, 0, 0, 1'b0);
    // backward x-major line with antialias, backward seek
    dir_cfg(REG_START_X, 4095);
    dir_cfg(REG_END_X, -4096);
    dir_cfg(REG_END_Y, 100);
    dir_req(CMD_BEGIN, 0, 0, 0, 1'b0);
    dir_req(CMD_SEEK, 1000, 0, 0, 1'b0);
    dir_req(CMD_SEEK, 999, 0, 0, 1'b0);
    dir_req(CMD_QUERY, 0, -4096, 0, 1'b1);
    // single-point line: no minor correction
    dir_cfg(REG_START_X, 5);
    dir_cfg(REG_START_Y, 5);
    dir_cfg(REG_END_X, 5);
    dir_cfg(REG_END_Y, 5);
    dir_cfg(REG_AA_ON, 0);
    dir_req(CMD_BEGIN, 0, 0, 0, 1'b0, 1'b1, mk_res(0, 4, 5, 4, 5, 0, 0));
    dir_req(CMD_SEEK, 0, 0, 0, 1'b0, 1'b1, mk_res(0, 5, 5, 5, 5, 0, 0));
    dir_req(CMD_QUERY, 0, 5, 5, 1'b0, 1'b1, mk_res(0, 5, 5, 5, 5, 0, 0));
    // steep negative line, antialias off
    dir_cfg(REG_START_X, 0);
    dir_cfg(REG_START_Y, 0);
    dir_cfg(REG_END_X, -3);
    dir_cfg(REG_END_Y, -20);
    dir_req(CMD_BEGIN, 0, 0, 0, 1'b0);
    dir_req(CMD_SEEK, 12, 0, 0, 1'b0);
    dir_req(CMD_SEEK, 2, 0, 0, 1'b0);

    // reset
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        wait_idle();
        apb_write(directed_rows[i].idx, int'($signed(directed_rows[i].val)));
      end else begin
        send_req(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);
      end
    end

    // random lines, mostly a well-formed run of requests after a begin, sometimes random requests without one
    first_phase = 1'b1;
    while (items_sent < ITEMS_TOTAL) begin
      wait_idle();
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        cx = int'($urandom_range(0, 8191)) - 4096;
        cy = int'($urandom_range(0, 8191)) - 4096;
        lx0 = cx + int'($urandom_range(0, 80)) - 40;
        ly0 = cy + int'($urandom_range(0, 80)) - 40;
        lx1 = cx + int'($urandom_range(0, 80)) - 40;
        ly1 = cy + int'($urandom_range(0, 80)) - 40;
      end else if (pick < 8) begin
        lx0 = int'($urandom_range(0, 8191)) - 4096;
        ly0 = int'($urandom_range(0, 8191)) - 4096;
        lx1 = int'($urandom_range(0, 8191)) - 4096;
        ly1 = int'($urandom_range(0, 8191)) - 4096;
      end else begin
        lx0 = ($urandom_range(0, 2) == 0) ? 0 : ($urandom_range(0, 1) ? 4095 : -4096);
        ly0 = ($urandom_range(0, 2) == 0) ? 0 : ($urandom_range(0, 1) ? 4095 : -4096);
        lx1 = ($urandom_range(0, 2) == 0) ? 0 : ($urandom_range(0, 1) ? 4095 : -4096);
        ly1 = ($urandom_range(0, 2) == 0) ? 0 : ($urandom_range(0, 1) ? 4095 : -4096);
      end
      apb_write(REG_START_X, lx0);
      apb_write(REG_START_Y, ly0);
      apb_write(REG_END_X, lx1);
      apb_write(REG_END_Y, ly1);
      apb_write(REG_AA_ON, int'($urandom_range(0, 1)));
      steady_tx = ($urandom_range(0, 3) == 0);
      noise = ($urandom_range(0, 7) == 0);
      // stall the receiver once while requests keep coming
      if (first_phase) begin
        hold_req = 1'b1;
        steady_tx = 1'b1;
        first_phase = 1'b0;
      end
      if (!noise) begin
        r = '0;
        r.cmd = CMD_BEGIN;
        send_req(r, 1'b0, '0);
      end
      n = $urandom_range(8, 40);
      repeat (n) begin
        r.step = 13'($urandom);
        r.tx = 13'($urandom);
        r.ty = 13'($urandom);
        r.use_off = 1'($urandom);
        r.cmd = 2'($urandom);
        if (!noise) begin
          k = $urandom_range(0, 99);
          if (k < 55) begin
            r.cmd = CMD_SEEK;
            sel = $urandom_range(0, 19);
            if (sel < 12)
              r.step = 13'($urandom_range(0, int'(span)));
            else if (sel < 15)
              r.step = 13'(n_step == 0 ? 0 : n_step - 1);
            else if (sel < 18)
              r.step = 13'($urandom_range(int'(span), 8191));
          end else if (k < 85) begin
            r.cmd = CMD_QUERY;
            // mostly points near the line, including one step off each end
            if ($urandom_range(0, 4) != 0) begin
              t = int'($urandom_range(0, int'(span) + 2)) - 1;
              m = int'($urandom_range(0, 6)) - 3;
              tx = int'(org_x + mj_x * t + mn_x * m + (r.use_off ? off_x : 0));
              ty = int'(org_y + mj_y * t + mn_y * m + (r.use_off ? off_y : 0));
              r.tx = 13'(tx);
              r.ty = 13'(ty);
            end
          end else if (k < 92) begin
            r.cmd = CMD_BEGIN;
          end else begin
            r.cmd = CMD_UNUSED;
          end
        end
        send_req(r, 1'b0, '0);
      end
    end

    // drain and let the pipeline settle
    wait_idle();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
